### sv/pnt_pkg.sv
// shared constants, register codes and sine rom builder for the pll nco tracker
// no dependencies
package pnt_pkg;

  localparam int SineTableBitsDef = 10;
  localparam int SampleWidthDef   = 16;
  localparam int PhaseWidthDef    = 32;

  localparam int RegW     = 32;
  localparam int GainW    = 17;
  localparam int CoefW    = 16;
  localparam int SineW    = 16;
  localparam int FracBits = 15;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [GainW-1:0] GainReset = 17'd2085;
  // -24225 in 16 bit two's complement
  localparam logic [CoefW-1:0] CoefReset = 16'hA15F;

  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_PHASE = 2'd0,
    REG_START_INC   = 2'd1,
    REG_GAIN_A      = 2'd2,
    REG_COEF_B      = 2'd3
  } cfg_reg_e;

  // round(32767*sin(2*pi*k/2^tb)) over the first quarter, q30 taylor series
  function automatic logic [SineW-1:0] quarter_sine(int unsigned k, int unsigned tb);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] tmp;
    logic [63:0] res;
    theta = (64'(k) * TwoPiQ30) >> tb;
    t2    = (theta * theta) >> 30;
    term  = theta;
    sum   = theta;
    for (int unsigned n = 1; n <= 12; n++) begin
      tmp = (term * t2) >> 30;
      case (n)
        1:       term = tmp / 64'd6;
        2:       term = tmp / 64'd20;
        3:       term = tmp / 64'd42;
        4:       term = tmp / 64'd72;
        5:       term = tmp / 64'd110;
        6:       term = tmp / 64'd156;
        7:       term = tmp / 64'd210;
        8:       term = tmp / 64'd272;
        9:       term = tmp / 64'd342;
        10:      term = tmp / 64'd420;
        11:      term = tmp / 64'd506;
        default: term = tmp / 64'd600;
      endcase
      if (n[0]) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    res = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (res > 64'd32767) begin
      res = 64'd32767;
    end
    return res[SineW-1:0];
  endfunction

endpackage

### sv/pll_nco_tracker_with_valid_gate.sv
// pll tracker: nco phase accumulator, sine rom, mixer and first-order loop filter
// one word at a time: a new input word is taken only once the last one's sine word
// has gone to the output register, which waits for output space, the rom read and the three
// passes through the one shared multiplier (mix, loop gain, history weight)
// reset: phase, increment and history clear, config regs take their defaults
// depends on pnt_pkg, pnt_sine_rom and pnt_mul
module pll_nco_tracker_with_valid_gate import pnt_pkg::*; #(
  parameter int SINE_TABLE_BITS = SineTableBitsDef,
  parameter int SAMPLE_WIDTH    = SampleWidthDef,
  parameter int PHASE_WIDTH     = PhaseWidthDef,
  localparam int InW            = ((SAMPLE_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sample, block_start, reload, zero pad
  input  logic [InW-1:0]      s_axis_tdata,
  // sample_valid
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // sine_out
  output logic [SineW-1:0]    m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int PW     = PHASE_WIDTH;
  localparam int SW     = SAMPLE_WIDTH;
  localparam int MaxSG  = (SW > GainW) ? SW : GainW;
  localparam int AW     = (PW > MaxSG) ? PW : MaxSG;
  localparam int BW     = GainW;
  localparam int ProdW  = AW + BW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROM  = 6'b000010,
    S_MIX  = 6'b000100,
    S_GAIN = 6'b001000,
    S_FB   = 6'b010000,
    S_UPD  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [RegW-1:0]  start_phase_q, start_inc_q;
  logic [GainW-1:0] gain_q;
  logic [CoefW-1:0] coef_q;

  logic [PW-1:0]           phase_q, inc_q, hist_q;
  logic signed [SW-1:0]    sample_q;
  logic                    valid_q;
  logic signed [SineW-1:0] sine_q;
  logic signed [SineW-1:0] rom_data;
  logic [SineW-1:0]        out_data_q;
  logic                    out_valid_q;

  logic                    in_fire, out_load;
  logic                    in_block_start, in_reload;
  logic [PW-1:0]           base_phase, base_inc;
  logic                    mul_en;
  logic signed [AW-1:0]    mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] ud_full, fb_full;
  logic signed [BW-1:0]    ud;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_block_start = s_axis_tdata[SW];
  assign in_reload      = s_axis_tdata[SW+1];
  assign out_load      = (state_q == S_UPD) && (!out_valid_q || m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_phase_q <= '0;
      start_inc_q   <= '0;
      gain_q        <= GainReset;
      coef_q        <= CoefReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_START_PHASE: start_phase_q <= cfg_data_i[RegW-1:0];
        REG_START_INC:   start_inc_q   <= cfg_data_i[RegW-1:0];
        REG_GAIN_A:      gain_q        <= cfg_data_i[GainW-1:0];
        REG_COEF_B:      coef_q        <= cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_ROM;
      S_ROM:   state_d = S_MIX;
      S_MIX:   state_d = S_GAIN;
      S_GAIN:  state_d = S_FB;
      S_FB:    state_d = S_UPD;
      S_UPD:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // start values are sign-extended or truncated to the phase width
  assign base_phase = in_reload ? PW'(signed'(start_phase_q)) : phase_q;
  assign base_inc   = in_reload ? PW'(signed'(start_inc_q))   : inc_q;

  assign ud_full = valid_q ? (prod >>> (SW - 1)) : (prod >>> FracBits);
  assign ud      = ud_full[BW-1:0];
  assign fb_full = prod >>> FracBits;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_MIX: begin
        mul_en = 1'b1;
        mul_a  = valid_q ? AW'(sample_q) : AW'(rom_data);
        mul_b  = BW'(rom_data);
      end
      S_GAIN: begin
        mul_en = 1'b1;
        mul_a  = AW'(ud);
        mul_b  = signed'(gain_q);
      end
      S_FB: begin
        // old history still in hist_q this cycle
        mul_en = 1'b1;
        mul_a  = AW'(signed'(hist_q));
        mul_b  = BW'(signed'(coef_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      inc_q   <= '0;
      hist_q  <= '0;
    end else begin
      if (in_fire) begin
        phase_q <= base_phase + base_inc;
        inc_q   <= base_inc;
        if (in_block_start) begin
          hist_q <= '0;
        end
      end
      if (state_q == S_FB) begin
        hist_q <= prod[PW-1:0];
      end
      if (out_load) begin
        inc_q <= inc_q + hist_q + fb_full[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= signed'(s_axis_tdata[SW-1:0]);
      valid_q  <= s_axis_tuser[0];
    end
    if (state_q == S_MIX) begin
      sine_q <= rom_data;
    end
    if (out_load) begin
      out_data_q <= sine_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  pnt_sine_rom #(
    .TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(phase_q[PW-1 -: SINE_TABLE_BITS]),
    .data_o(rom_data)
  );

  pnt_mul #(
    .A_WIDTH(AW),
    .B_WIDTH(BW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

endmodule

### sv/pnt_sine_rom.sv
// full-wave sine rom with registered read data
// depends on pnt_pkg for the quarter-wave builder
module pnt_sine_rom import pnt_pkg::*; #(
  parameter int TABLE_BITS = SineTableBitsDef
) (
  input  logic                    clk_i,
  input  logic [TABLE_BITS-1:0]   addr_i,
  output logic signed [SineW-1:0] data_o
);

  localparam int Depth   = 1 << TABLE_BITS;
  localparam int Quarter = Depth / 4;

  typedef logic signed [SineW-1:0] rom_t [Depth];

  // quarter wave mirrored into the other three quadrants
  function automatic rom_t build_rom();
    rom_t                    t;
    logic [TABLE_BITS-1:0]   idx;
    logic [TABLE_BITS-3:0]   r;
    logic signed [SineW-1:0] s;
    for (int i = 0; i < Depth; i++) begin
      idx = TABLE_BITS'(i);
      r   = idx[TABLE_BITS-3:0];
      if (idx[TABLE_BITS-2]) begin
        s = signed'(quarter_sine(Quarter - int'(r), TABLE_BITS));
      end else begin
        s = signed'(quarter_sine(int'(r), TABLE_BITS));
      end
      t[i] = idx[TABLE_BITS-1] ? -s : s;
    end
    return t;
  endfunction

  localparam rom_t Rom = build_rom();

  logic signed [SineW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= Rom[addr_i];
  end

  assign data_o = data_q;

endmodule

### sv/pnt_mul.sv
// shared signed multiplier with registered product
// depends on pnt_pkg for default widths
module pnt_mul import pnt_pkg::*; #(
  parameter int A_WIDTH = PhaseWidthDef,
  parameter int B_WIDTH = GainW
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [A_WIDTH-1:0]         a_i,
  input  logic signed [B_WIDTH-1:0]         b_i,
  output logic signed [A_WIDTH+B_WIDTH-1:0] prod_o
);

  logic signed [A_WIDTH+B_WIDTH-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (A_WIDTH+B_WIDTH)'(a_i) * (A_WIDTH+B_WIDTH)'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

### sv/pnt_checker.sv
// port-level checks on the pll tracker handshakes, bound to the top level
// depends on pnt_pkg for widths
module pnt_checker import pnt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [SineW-1:0] m_axis_tdata,
  input logic             cfg_ready_o
);

  // one word in flight: busy straight after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again right after an accept");

  // a result cannot appear in the cycle after its word was taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##1 !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // the block is idle again when a fresh result shows up
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result raised while still busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind pll_nco_tracker_with_valid_gate pnt_checker u_pnt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .cfg_ready_o  (cfg_ready_o)
);
